// ===== hdl/depth_view_warp_hole_fill_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the depth view warp block
// Clocked on clk; the first form is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DEPTH_VIEW_WARP_HOLE_FILL_MACROS_SVH
`define DEPTH_VIEW_WARP_HOLE_FILL_MACROS_SVH
`ifndef ASSERT_OFF
`define DVHF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DVHF_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DVHF_ASSERT(lbl, prop, msg)
`define DVHF_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== hdl/dvhf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvhf_pkg
// Widths, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dvhf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int COL_W      = ADDR_W + 1;
  localparam int MEM_AW     = ADDR_W + 1;
  localparam int COLOR_W    = 24;
  localparam int DEPTH_W    = 16;
  localparam int IW_W       = 12;
  localparam int GAIN_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = DEPTH_W + 1 + GAIN_W;
  localparam int TP_W       = PROD_W - FRAC_W + 1;
  localparam int SH_W       = COL_W + 1;
  localparam int NUM_W      = 2 * COL_W + 3;
  localparam int LIM_W      = 2 * COL_W;
  localparam int CNT_W      = $clog2(COL_W + 1);
  localparam int CMP_W      = (IW_W > COL_W) ? IW_W : COL_W;

  localparam logic [IW_W-1:0]    RESET_WIDTH = IW_W'(640);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = '1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WIGGLE_GAIN  = CFG_IDX_W'(2);

  typedef struct packed {
    logic accept;
    logic p2_rd;
    logic commit;
    logic rd_x;
    logic take_prev;
    logic run_start;
    logic rd_e;
    logic take_next;
    logic e_inc;
    logic mul_num;
    logic mul_lim;
    logic div_start;
    logic rd_src;
    logic wr_zero;
    logic wr_src;
    logic next_pix;
    logic x_to_e;
    logic finish;
  } dvhf_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_func;
    logic row_end;
    logic x_ge_n;
    logic e_ge_n;
    logic rd_valid;
    logic num_ok;
    logic div_busy;
    logic pix_last;
    logic clr_busy;
  } dvhf_sts_t;

  function automatic logic [COL_W-1:0] eff_width(logic [IW_W-1:0] w);
    logic [CMP_W-1:0] wx;
    wx = CMP_W'(w);
    if (wx == '0) return COL_W'(1);
    if (wx > CMP_W'(MAX_WIDTH)) return COL_W'(MAX_WIDTH);
    return COL_W'(wx);
  endfunction

endpackage

// ===== hdl/dvhf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvhf_div
// Restoring divider, one quotient bit per cycle; quotient known to fit COL_W.
// ----------------------------------------------------------------------------
module dvhf_div import dvhf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LIM_W-1:0] dividend,
  input  logic [COL_W-1:0] divisor,
  output logic             busy,
  output logic [COL_W-1:0] quot
);

  logic [CNT_W-1:0] cnt;
  logic [COL_W-1:0] rem;
  logic [COL_W-1:0] lo;
  logic [COL_W-1:0] q;
  logic [COL_W:0]   trial;
  logic [COL_W:0]   diff;
  logic             ge;

  assign trial = {rem, lo[COL_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(COL_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[LIM_W-1:COL_W];
      lo  <= dividend[COL_W-1:0];
    end else if (busy) begin
      rem <= ge ? diff[COL_W-1:0] : trial[COL_W-1:0];
      lo  <= {lo[COL_W-2:0], 1'b0};
      q   <= {q[COL_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/dvhf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvhf_dp
// Row memories, warp arithmetic, hole interpolation and output register.
// ----------------------------------------------------------------------------
module dvhf_dp import dvhf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  func,
  input  logic [COLOR_W-1:0]    color,
  input  logic [DEPTH_W-1:0]    depth,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [COLOR_W-1:0]    out_color,
  output logic                  last_in_row,
  input  dvhf_cmd_t             cmd,
  output dvhf_sts_t             sts
);

  // configuration
  logic [IW_W-1:0]           image_width;
  logic [DEPTH_W-1:0]        depth_offset;
  logic signed [GAIN_W-1:0]  wiggle_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      depth_offset <= '0;
      wiggle_gain  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IW_W-1:0];
        REG_DEPTH_OFFSET: depth_offset <= cfg_data[DEPTH_W-1:0];
        REG_WIGGLE_GAIN:  wiggle_gain  <= $signed(cfg_data[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  logic [COL_W-1:0] eff_w;
  assign eff_w = eff_width(image_width);

  // memories
  logic [COLOR_W-1:0] src_mem [2**MEM_AW];
  logic [COLOR_W-1:0] col_mem [2**MEM_AW];
  logic [DEPTH_W-1:0] dep_mem [2**MEM_AW];
  logic [SH_W-1:0]    sh_mem  [2**MEM_AW];
  logic               val_mem [2**MEM_AW];

  logic [COLOR_W-1:0] src_rd, col_rd;
  logic [DEPTH_W-1:0] dep_rd;
  logic [SH_W-1:0]    sh_rd;
  logic               val_rd;

  // control state
  logic             wb;
  logic [COL_W-1:0] in_col;
  logic             held_valid;
  logic [COL_W-1:0] held_w;
  logic [COL_W-1:0] out_col;
  logic             res_pend;
  logic             res_last;

  // beat under work
  logic               in_func;
  logic [COLOR_W-1:0] in_color;
  logic [DEPTH_W-1:0] in_depth;

  // warp arithmetic
  logic signed [DEPTH_W:0]  dval;
  logic signed [PROD_W-1:0] prod;
  logic signed [TP_W-2:0]   pshift;
  logic signed [TP_W-1:0]   tpos;
  logic [TP_W-2:0]          s_full;
  logic                     round_up;
  logic                     t_ok_c;
  logic                     t_ok;
  logic [ADDR_W-1:0]        t_addr;
  logic [SH_W-1:0]          s_val;
  logic                     win;

  assign dval     = $signed({1'b0, in_depth}) - $signed({1'b0, depth_offset});
  assign pshift   = prod[PROD_W-1:FRAC_W];
  assign tpos     = {pshift[TP_W-2], pshift} + $signed({{(TP_W-COL_W){1'b0}}, in_col});
  assign round_up = prod[PROD_W-1] && (prod[FRAC_W-1:0] != '0);
  assign s_full   = pshift + {{(TP_W-2){1'b0}}, round_up};
  assign t_ok_c   = (in_depth != '0) && !tpos[TP_W-1]
                    && (tpos[TP_W-2:0] < {{(TP_W-1-COL_W){1'b0}}, eff_w});
  assign win      = t_ok && (val_rd ? (in_depth < dep_rd) : (in_depth != DEPTH_MAX));

  always_ff @(posedge clk) begin
    prod <= dval * wiggle_gain;
    if (cmd.p2_rd) begin
      t_ok   <= t_ok_c;
      t_addr <= tpos[ADDR_W-1:0];
      s_val  <= s_full[SH_W-1:0];
    end
    if (cmd.accept) begin
      in_func  <= func;
      in_color <= color;
      in_depth <= depth;
    end
  end

  // hole fill
  logic [COL_W-1:0]        n, x, e, pos, len_r, len_c;
  logic signed [SH_W-1:0]  prev_sh, next_sh;
  logic signed [NUM_W-1:0] num, step, num_c, step_c;
  logic signed [COL_W+1:0] diff;
  logic [LIM_W-1:0]        lim;
  logic [COL_W-1:0]        quot;
  logic                    div_busy;

  assign len_c  = e - pos;
  assign diff   = $signed({2'b00, pos}) - $signed({prev_sh[SH_W-1], prev_sh});
  assign num_c  = $signed({1'b0, len_c}) * diff;
  assign step_c = $signed({{(NUM_W-COL_W){1'b0}}, len_c})
                  + $signed({{(NUM_W-SH_W){prev_sh[SH_W-1]}}, prev_sh})
                  - $signed({{(NUM_W-SH_W){next_sh[SH_W-1]}}, next_sh});

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      n       <= in_col + COL_W'(1);
      x       <= '0;
      prev_sh <= '0;
      next_sh <= '0;
    end
    if (cmd.take_prev) begin
      prev_sh <= sh_rd;
      x       <= x + COL_W'(1);
    end
    if (cmd.run_start) begin
      pos <= x;
      e   <= x + COL_W'(1);
    end
    if (cmd.e_inc) e <= e + COL_W'(1);
    if (cmd.take_next) next_sh <= sh_rd;
    if (cmd.mul_num) begin
      len_r <= len_c;
      num   <= num_c;
      step  <= step_c;
    end
    if (cmd.mul_lim) lim <= n * len_r;
    if (cmd.next_pix) begin
      pos <= pos + COL_W'(1);
      num <= num + step;
    end
    if (cmd.x_to_e) x <= e;
  end

  dvhf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (num[LIM_W-1:0]),
    .divisor  (len_r),
    .busy     (div_busy),
    .quot     (quot)
  );

  // valid-bit clearing sweep
  logic              clr_busy;
  logic [MEM_AW-1:0] clr_addr;
  logic [MEM_AW-1:0] clr_stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      clr_stop <= '1;
    end else if (cmd.commit && sts.row_end) begin
      clr_busy <= 1'b1;
      clr_addr <= {~wb, {ADDR_W{1'b0}}};
      clr_stop <= {~wb, {ADDR_W{1'b1}}};
    end else if (clr_busy) begin
      clr_addr <= clr_addr + MEM_AW'(1);
      if (clr_addr == clr_stop) clr_busy <= 1'b0;
    end
  end

  // memory ports
  logic [MEM_AW-1:0] scan_addr;
  assign scan_addr = cmd.rd_e ? {wb, e[ADDR_W-1:0]} : {wb, x[ADDR_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.accept && !func) src_mem[{wb, in_col[ADDR_W-1:0]}] <= color;
    if (cmd.rd_src) src_rd <= src_mem[{wb, quot[ADDR_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && win) col_mem[{wb, t_addr}] <= in_color;
    else if (cmd.wr_zero) col_mem[{wb, pos[ADDR_W-1:0]}] <= '0;
    else if (cmd.wr_src) col_mem[{wb, pos[ADDR_W-1:0]}] <= src_rd;
    if (cmd.accept) col_rd <= col_mem[{~wb, out_col[ADDR_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && win) dep_mem[{wb, t_addr}] <= in_depth;
    if (cmd.p2_rd) dep_rd <= dep_mem[{wb, tpos[ADDR_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && win) sh_mem[{wb, t_addr}] <= s_val;
    if (cmd.rd_x || cmd.rd_e) sh_rd <= sh_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (clr_busy) val_mem[clr_addr] <= 1'b0;
    else if (cmd.commit && win) val_mem[{wb, t_addr}] <= 1'b1;
    if (cmd.p2_rd) val_rd <= val_mem[{wb, tpos[ADDR_W-1:0]}];
    else if (cmd.rd_x || cmd.rd_e) val_rd <= val_mem[scan_addr];
  end

  // row bookkeeping and output
  always_ff @(posedge clk) begin
    if (rst) begin
      wb          <= 1'b0;
      in_col      <= '0;
      held_valid  <= 1'b0;
      held_w      <= '0;
      out_col     <= '0;
      res_pend    <= 1'b0;
      res_last    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        res_pend <= held_valid && (out_col < held_w);
        res_last <= (out_col + COL_W'(1)) >= held_w;
        if (held_valid && (out_col < held_w)) begin
          out_col <= out_col + COL_W'(1);
          if ((out_col + COL_W'(1)) >= held_w) held_valid <= 1'b0;
        end
      end else if (res_pend) begin
        res_pend <= 1'b0;
      end
      if (res_pend) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.commit) in_col <= sts.row_end ? '0 : in_col + COL_W'(1);
      if (cmd.finish) begin
        wb         <= ~wb;
        held_valid <= 1'b1;
        held_w     <= n;
        out_col    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_pend) begin
      out_color   <= col_rd;
      last_in_row <= res_last;
    end
  end

  always_comb begin
    sts.out_free = !out_valid || out_ready;
    sts.in_func  = in_func;
    sts.row_end  = (in_col + COL_W'(1)) >= eff_w;
    sts.x_ge_n   = x >= n;
    sts.e_ge_n   = e >= n;
    sts.rd_valid = val_rd;
    sts.num_ok   = !num[NUM_W-1]
                   && (num[NUM_W-2:0] < {{(NUM_W-1-LIM_W){1'b0}}, lim});
    sts.div_busy = div_busy;
    sts.pix_last = (pos + COL_W'(1)) == e;
    sts.clr_busy = clr_busy;
  end

endmodule

// ===== hdl/dvhf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvhf_ctrl
// Sequencer: pixel warp steps, row-end hole fill scan, clearing waits.
// ----------------------------------------------------------------------------
module dvhf_ctrl import dvhf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dvhf_sts_t sts,
  output dvhf_cmd_t cmd
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_P1   = 5'd2;
  localparam logic [4:0] S_P2   = 5'd3;
  localparam logic [4:0] S_P3   = 5'd4;
  localparam logic [4:0] S_RDX  = 5'd5;
  localparam logic [4:0] S_CHKX = 5'd6;
  localparam logic [4:0] S_RDE  = 5'd7;
  localparam logic [4:0] S_CHKE = 5'd8;
  localparam logic [4:0] S_MUL  = 5'd9;
  localparam logic [4:0] S_LIM  = 5'd10;
  localparam logic [4:0] S_PIX  = 5'd11;
  localparam logic [4:0] S_DIV  = 5'd12;
  localparam logic [4:0] S_SRC  = 5'd13;
  localparam logic [4:0] S_NEXT = 5'd14;
  localparam logic [4:0] S_DONE = 5'd15;

  logic [4:0] state, state_next;

  assign in_ready = (state == S_IDLE) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLR:  if (!sts.clr_busy) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          state_next = S_P1;
        end
      end
      S_P1:   state_next = sts.in_func ? S_IDLE : S_P2;
      S_P2: begin
        cmd.p2_rd  = 1'b1;
        state_next = S_P3;
      end
      S_P3: begin
        cmd.commit = 1'b1;
        state_next = sts.row_end ? S_RDX : S_IDLE;
      end
      S_RDX: begin
        if (sts.x_ge_n) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_x   = 1'b1;
          state_next = S_CHKX;
        end
      end
      S_CHKX: begin
        if (sts.rd_valid) begin
          cmd.take_prev = 1'b1;
          state_next    = S_RDX;
        end else begin
          cmd.run_start = 1'b1;
          state_next    = S_RDE;
        end
      end
      S_RDE: begin
        if (sts.e_ge_n) begin
          state_next = S_MUL;
        end else begin
          cmd.rd_e   = 1'b1;
          state_next = S_CHKE;
        end
      end
      S_CHKE: begin
        if (sts.rd_valid) begin
          cmd.take_next = 1'b1;
          state_next    = S_MUL;
        end else begin
          cmd.e_inc  = 1'b1;
          state_next = S_RDE;
        end
      end
      S_MUL: begin
        cmd.mul_num = 1'b1;
        state_next  = S_LIM;
      end
      S_LIM: begin
        cmd.mul_lim = 1'b1;
        state_next  = S_PIX;
      end
      S_PIX: begin
        if (sts.num_ok) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.wr_zero = 1'b1;
          state_next  = S_NEXT;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.rd_src = 1'b1;
          state_next = S_SRC;
        end
      end
      S_SRC: begin
        cmd.wr_src = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (sts.pix_last) begin
          cmd.x_to_e = 1'b1;
          state_next = S_RDX;
        end else begin
          cmd.next_pix = 1'b1;
          state_next   = S_PIX;
        end
      end
      S_DONE: begin
        if (!sts.clr_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule

// ===== hdl/depth_view_warp_hole_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_view_warp_hole_fill
// Depth based view warp of a raster pixel stream with hole filling.
// ----------------------------------------------------------------------------
// Input beats (func, color, depth) arrive on in_valid/in_ready; func 0 is a
// pixel, func 1 a flush. Each accepted beat also pops one pixel of the held
// (previous, already filled) row onto out_valid/out_ready, with last_in_row
// on the row's final pixel; no pixel is popped when no row is held.
// The result is registered in the cycle after the accepting edge.
// A pixel beat passes through the multiply, address/read, and depth test and
// write steps; a flush returns to idle after the first of them. The beat that
// completes a row then runs the hole fill scan: each column is read and
// checked, each hole run is measured and set up for interpolation, and each
// hole pixel either samples the source row (one quotient bit a cycle in the
// divider) or is written black; the valid-bit sweep of the freed bank runs
// beside the scan and the longer of the two sets the row-end pause.
// After reset the valid bits of both banks are swept with in_ready low;
// configuration writes are taken at any time. A stalled receiver holds
// in_ready low while a result waits in the output register.
// ----------------------------------------------------------------------------
`include "depth_view_warp_hole_fill_macros.svh"
module depth_view_warp_hole_fill import dvhf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [COLOR_W-1:0]    color,
  input  logic [DEPTH_W-1:0]    depth,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOR_W-1:0]    out_color,
  output logic                  last_in_row
);

  dvhf_cmd_t cmd;
  dvhf_sts_t sts;

  dvhf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dvhf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .color       (color),
    .depth       (depth),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_color   (out_color),
    .last_in_row (last_in_row),
    .cmd         (cmd),
    .sts         (sts)
  );

  `DVHF_ASSERT(a_accept_slot, (in_valid && in_ready) |-> (!out_valid || out_ready), "accept with output slot busy")
  `DVHF_ASSERT(a_out_after_accept, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without accepted beat")
  `DVHF_ASSERT(a_no_accept_clear, sts.clr_busy |-> !in_ready, "ready during valid-bit sweep")
  `DVHF_ASSERT_NR(a_reset_quiet, rst |=> (!out_valid && !in_ready), "activity right after reset")

endmodule
